// ----- hdl/gzhp_pkg.sv -----
// ----------------------------------------------------------------------------
// gzhp_pkg
// Types, codes and helper functions shared by the gzip header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  // header section tags, also used as the parse phase
  typedef enum logic [2:0] {
    SEC_FIXED   = 3'd0,
    SEC_XLEN    = 3'd1,
    SEC_XDATA   = 3'd2,
    SEC_NAME    = 3'd3,
    SEC_COMMENT = 3'd4,
    SEC_HCRC    = 3'd5,
    SEC_PAYLOAD = 3'd6,
    SEC_ERROR   = 3'd7
  } section_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_METHOD    = 3'd3,
    ST_CHECKSUM  = 3'd4
  } status_t;

  localparam logic [7:0]  GZ_ID1         = 8'h1F;
  localparam logic [7:0]  GZ_ID2         = 8'h8B;
  localparam logic [7:0]  GZ_CM_DEFLATE  = 8'd8;
  localparam logic [7:0]  GZ_FLG_RSVD    = 8'hE0;
  localparam logic [3:0]  GZ_FIXED_LAST  = 4'd9;
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET     = 32'hFFFFFFFF;

  // flag bit positions inside the 5-bit flag register
  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  // reflected crc-32, one byte folded in
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // section that follows 'from' given the header flags
  function automatic section_t next_section(input section_t from, input logic [4:0] flg);
    section_t s;
    if (from < SEC_XLEN && flg[FLG_EXTRA]) begin
      s = SEC_XLEN;
    end else if (from < SEC_NAME && flg[FLG_NAME]) begin
      s = SEC_NAME;
    end else if (from < SEC_COMMENT && flg[FLG_COMMENT]) begin
      s = SEC_COMMENT;
    end else if (from < SEC_HCRC && flg[FLG_HCRC]) begin
      s = SEC_HCRC;
    end else begin
      s = SEC_PAYLOAD;
    end
    return s;
  endfunction

endpackage

// ----- hdl/gzip_header_parser.sv -----
// ----------------------------------------------------------------------------
// gzip_header_parser
// Byte-wide gzip (RFC 1952) header parser with section tagging and status.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stream byte per word in in_tdata, in_tlast marks the final
//           byte of a gzip stream.
//   out_* : one result word per input word. out_tuser carries the section
//           tag, out_tdata the passed-through byte plus header_done, status,
//           flags and modification time, out_tlast echoes the stream end.
// The accepted word sits in the input register, then parse logic (byte-wide
// crc-32 and phase update) feeds the result register, which drives the
// result. Throughput is one byte per cycle while the output is not stalled;
// the crc update and the phase logic are both combinational between the two
// registers.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of the fixed header. The parser also restarts by
// itself after every byte marked with in_tlast.
// When out_tready is low the result register holds; the input register
// still takes one more word if it is empty, after which in_tready drops until the result
// is taken.
// ----------------------------------------------------------------------------
module gzip_header_parser
  import gzhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] byte_out, [8] header_done, [11:9] status,
                                  // [16:12] header_flags, [48:17] mod_time, rest zero
  output logic [2:0]  out_tuser,  // [2:0] section
  output logic        out_tlast
);

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // result register
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_done_r;
  status_t    out_status_r;
  logic [4:0] out_flags_r;
  logic [31:0] out_time_r;
  section_t   out_sec_r;
  logic       out_end_r;

  // parser state
  section_t    phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] xrem_r, xrem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [4:0]  flag_r, flag_nxt;
  logic [31:0] time_r, time_nxt;
  logic [7:0]  method_r, method_nxt;
  logic        id_bad_r, id_bad_nxt;
  logic        flg_bad_r, flg_bad_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  status_t     err_code_r, err_code_nxt;

  logic        adv;
  logic        go;
  section_t    tgt;
  status_t     err;
  status_t     status;
  logic        done;
  logic [15:0] xlen;
  logic [15:0] xdec;
  logic [7:0]  b;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;
  assign b         = s1_byte_r;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    xrem_nxt     = xrem_r;
    crc_nxt      = crc_r;
    flag_nxt     = flag_r;
    time_nxt     = time_r;
    method_nxt   = method_r;
    id_bad_nxt   = id_bad_r;
    flg_bad_nxt  = flg_bad_r;
    crc_lo_nxt   = crc_lo_r;
    err_code_nxt = err_code_r;
    go     = 1'b0;
    tgt    = SEC_PAYLOAD;
    err    = ST_OK;
    status = ST_OK;
    done   = 1'b0;
    xlen   = {b, xrem_r[7:0]};
    xdec   = xrem_r - 16'd1;

    case (phase_r)
      SEC_FIXED: begin
        crc_nxt = crc_byte(crc_r, b);
        case (cnt_r)
          4'd0: id_bad_nxt = (b != GZ_ID1);
          4'd1: if (b != GZ_ID2) id_bad_nxt = 1'b1;
          4'd2: method_nxt = b;
          4'd3: begin
            flag_nxt    = b[4:0];
            flg_bad_nxt = (b & GZ_FLG_RSVD) != 8'd0;
          end
          4'd4: time_nxt = {24'd0, b};
          4'd5: time_nxt = time_r | {16'd0, b, 8'd0};
          4'd6: time_nxt = time_r | {8'd0, b, 16'd0};
          4'd7: time_nxt = time_r | {b, 24'd0};
          default: ;
        endcase
        if (cnt_r >= GZ_FIXED_LAST) begin
          if (id_bad_r || method_r < GZ_CM_DEFLATE || flg_bad_r) begin
            err = ST_MALFORMED;
          end else if (method_r != GZ_CM_DEFLATE) begin
            err = ST_METHOD;
          end else begin
            go  = 1'b1;
            tgt = next_section(SEC_FIXED, flag_r);
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      SEC_XLEN: begin
        crc_nxt = crc_byte(crc_r, b);
        if (cnt_r == 4'd0) begin
          xrem_nxt = {8'd0, b};
          cnt_nxt  = 4'd1;
        end else begin
          xrem_nxt = xlen;
          go       = 1'b1;
          tgt      = (xlen == 16'd0) ? next_section(SEC_XDATA, flag_r) : SEC_XDATA;
        end
      end
      SEC_XDATA: begin
        crc_nxt  = crc_byte(crc_r, b);
        xrem_nxt = xdec;
        if (xdec == 16'd0) begin
          go  = 1'b1;
          tgt = next_section(SEC_XDATA, flag_r);
        end
      end
      SEC_NAME, SEC_COMMENT: begin
        crc_nxt = crc_byte(crc_r, b);
        if (b == 8'd0) begin
          go  = 1'b1;
          tgt = next_section(phase_r, flag_r);
        end
      end
      SEC_HCRC: begin
        if (cnt_r == 4'd0) begin
          crc_lo_nxt = b;
          cnt_nxt    = 4'd1;
        end else if (~crc_r[15:0] != {b, crc_lo_r}) begin
          err = ST_CHECKSUM;
        end else begin
          go  = 1'b1;
          tgt = SEC_PAYLOAD;
        end
      end
      default: ;
    endcase

    if (go) begin
      phase_nxt = tgt;
      cnt_nxt   = 4'd0;
      done      = (tgt == SEC_PAYLOAD);
    end

    if (phase_r == SEC_ERROR) begin
      status = err_code_r;
    end else if (err != ST_OK) begin
      err_code_nxt = err;
      phase_nxt    = SEC_ERROR;
      status       = err;
    end else if (s1_end_r && phase_nxt < SEC_PAYLOAD) begin
      // stream ended inside the header
      err_code_nxt = ST_TRUNC;
      status       = ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      phase_r    <= SEC_FIXED;
      cnt_r      <= 4'd0;
      xrem_r     <= 16'd0;
      crc_r      <= CRC_PRESET;
      flag_r     <= 5'd0;
      time_r     <= 32'd0;
      method_r   <= 8'd0;
      id_bad_r   <= 1'b0;
      flg_bad_r  <= 1'b0;
      crc_lo_r   <= 8'd0;
      err_code_r <= ST_OK;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (adv && s1_vld_r) begin
        if (s1_end_r) begin
          // restart for the next stream
          phase_r    <= SEC_FIXED;
          cnt_r      <= 4'd0;
          xrem_r     <= 16'd0;
          crc_r      <= CRC_PRESET;
          flag_r     <= 5'd0;
          time_r     <= 32'd0;
          method_r   <= 8'd0;
          id_bad_r   <= 1'b0;
          flg_bad_r  <= 1'b0;
          crc_lo_r   <= 8'd0;
          err_code_r <= ST_OK;
        end else begin
          phase_r    <= phase_nxt;
          cnt_r      <= cnt_nxt;
          xrem_r     <= xrem_nxt;
          crc_r      <= crc_nxt;
          flag_r     <= flag_nxt;
          time_r     <= time_nxt;
          method_r   <= method_nxt;
          id_bad_r   <= id_bad_nxt;
          flg_bad_r  <= flg_bad_nxt;
          crc_lo_r   <= crc_lo_nxt;
          err_code_r <= err_code_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
    if (adv && s1_vld_r) begin
      out_byte_r   <= s1_byte_r;
      out_done_r   <= done;
      out_status_r <= status;
      out_flags_r  <= flag_nxt;
      out_time_r   <= time_nxt;
      out_sec_r    <= phase_r;
      out_end_r    <= s1_end_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_time_r, out_flags_r, out_status_r, out_done_r, out_byte_r};
  assign out_tuser  = out_sec_r;
  assign out_tlast  = out_end_r;

endmodule
